/* src/sliding_window_max_min_filter_1d_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window max/min filter
// Each macro names its check, samples on the rising edge of clk and is
// switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAX_MIN_FILTER_1D_ASSERT_SVH
`define SLIDING_WINDOW_MAX_MIN_FILTER_1D_ASSERT_SVH

// Same-cycle implication.
`define SWMM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define SWMM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* src/swmm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_pkg
// Types and constants shared by the sliding window max/min filter modules.
// ----------------------------------------------------------------------------
package swmm_pkg;

    localparam int PIX_W = 8;
    localparam int WS_W  = 6;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_WINDOW_SIZE = 1'b0,
        REG_TAKE_MAX    = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             row_last_in;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             row_last_out;
    } pix_out_t;

    // Running maximum and minimum held by one cell
    typedef struct packed {
        logic [PIX_W-1:0] mx;
        logic [PIX_W-1:0] mn;
    } minmax_t;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic             advance;
        logic             row_start;
        logic [PIX_W-1:0] pixel;
    } chain_ctrl_t;

endpackage
`default_nettype wire

/* src/swmm_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_cell
// One stage of the prefix chain: max and min of the newest pixel and the
// left neighbour's running values, restarted at the first pixel of a row.
// ----------------------------------------------------------------------------
module swmm_cell (
    input  wire logic                  clk,
    input  wire swmm_pkg::chain_ctrl_t ctrl,
    input  wire swmm_pkg::minmax_t     left,
    output swmm_pkg::minmax_t          q
);
    import swmm_pkg::*;

    minmax_t cell_reg;
    minmax_t cell_next;

    always_comb
    begin
        if (ctrl.row_start)
        begin
            cell_next.mx = ctrl.pixel;
            cell_next.mn = ctrl.pixel;
        end
        else
        begin
            cell_next.mx = (ctrl.pixel > left.mx) ? ctrl.pixel : left.mx;
            cell_next.mn = (ctrl.pixel < left.mn) ? ctrl.pixel : left.mn;
        end
    end

    // advance only on an accepted beat
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            cell_reg <= cell_next;
        end
    end

    assign q = cell_reg;

endmodule
`default_nettype wire

/* src/swmm_chain.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_chain
// Row of N cells; cell k holds the max and min of the newest k+1 pixels of
// the current row, clipped at the row start. One read port selects a cell.
// ----------------------------------------------------------------------------
module swmm_chain #(
    parameter int N = 63
) (
    input  wire logic                    clk,
    input  wire swmm_pkg::chain_ctrl_t   ctrl,
    input  wire logic [$clog2(N)-1:0]    rd_idx,
    output swmm_pkg::minmax_t            rd_data
);
    import swmm_pkg::*;

    minmax_t taps [N];
    minmax_t head;

    assign head.mx = ctrl.pixel;
    assign head.mn = ctrl.pixel;

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        if (k == 0)
        begin : g_first
            swmm_cell u_cell (
                .clk  (clk),
                .ctrl (ctrl),
                .left (head),
                .q    (taps[k])
            );
        end
        else
        begin : g_rest
            swmm_cell u_cell (
                .clk  (clk),
                .ctrl (ctrl),
                .left (taps[k-1]),
                .q    (taps[k])
            );
        end
    end

    assign rd_data = taps[rd_idx];

endmodule
`default_nettype wire

/* src/sliding_window_max_min_filter_1d.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_max_min_filter_1d
// 1-D grey-scale dilation / erosion over a clipped window, one row at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the in_* valid/ready channel, one beat per pixel, with
//   row_last_in set on the final pixel of a row. Results leave on the out_*
//   channel; row_last_out marks the final result of a row.
//   Output j appears once input j+half has been taken (half = window_size/2,
//   clamped to (MAX_WINDOW-1)/2). A result is registered, so it sits in the
//   output register in the cycle after the beat that caused it.
//   Inside a row the block takes one pixel per cycle while the output is not
//   stalled: a chain of MAX_WINDOW cells keeps running max/min prefixes, so
//   each result is one cell read plus one compare. At the last pixel of a row
//   the remaining results are read out of the frozen chain, one per cycle
//   while the receiver takes them; this tail holds in_ready low until it ends.
//   When the receiver stalls, the output register holds its beat and in_ready
//   falls until it is taken. Reset empties the output, restarts the row count
//   and sets window_size to 3 and take_max to 1; the cells are reloaded by the
//   first pixel of each row, so they need no clearing.
//   Configuration writes (cfg_we) take effect at once and may fall between
//   rows or between beats of a row.
// ----------------------------------------------------------------------------
`include "sliding_window_max_min_filter_1d_assert.svh"

module sliding_window_max_min_filter_1d #(
    parameter int MAX_WINDOW = 63
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire swmm_pkg::pix_in_t           in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output swmm_pkg::pix_out_t               out_data,
    input  wire logic                        cfg_we,
    input  wire swmm_pkg::cfg_reg_t          cfg_index,
    input  wire logic [swmm_pkg::WS_W-1:0]   cfg_data
);
    import swmm_pkg::*;

    localparam int IDX_W    = $clog2(MAX_WINDOW);
    localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
    localparam int HALF_LIM = (MAX_WINDOW - 1) / 2;

    // configuration
    logic [WS_W-1:0]  window_size_reg;
    logic             take_max_reg;

    // row bookkeeping
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // end-of-row tail
    logic             drain_reg;
    logic [IDX_W-1:0] d_reg;
    logic [IDX_W-1:0] h_sv_reg;
    logic [IDX_W-1:0] cm1_sv_reg;

    // output register
    logic             out_valid_reg;
    pix_out_t         out_data_reg;
    pix_out_t         res;

    logic [WS_W-2:0]  half_raw;
    logic [IDX_W-1:0] half;
    logic [IDX_W-1:0] cm1;
    logic [IDX_W-1:0] top;
    logic [IDX_W:0]   two_h;
    logic [IDX_W:0]   tph;
    logic [IDX_W:0]   dph;
    logic [IDX_W-1:0] sel;
    logic [IDX_W-1:0] drain_sel;
    logic [IDX_W-1:0] rd_idx;
    minmax_t          rd_data;
    chain_ctrl_t      ctrl;
    logic             row_start;
    logic             last;
    logic             emit;
    logic             in_fire;
    logic             out_free;
    logic             drain_fire;
    logic             load;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] acc_pix;
    logic [PIX_W-1:0] drain_pix;

    assign x    = in_data.pixel_in;
    assign last = in_data.row_last_in;

    // half-width, clamped to what the chain can hold
    assign half_raw = window_size_reg[WS_W-1:1];

    always_comb
    begin
        if (int'(half_raw) > HALF_LIM)
        begin
            half = IDX_W'(HALF_LIM);
        end
        else
        begin
            half = IDX_W'(half_raw);
        end
    end

    // pixels of the row before this one, capped at MAX_WINDOW-1, i.e. row length minus one after it
    always_comb
    begin
        if (int'(count_reg) >= MAX_WINDOW)
        begin
            cm1 = IDX_W'(MAX_WINDOW - 1);
        end
        else
        begin
            cm1 = count_reg[IDX_W-1:0];
        end
    end

    assign row_start = (count_reg == '0);
    assign top       = (half < cm1) ? half : cm1;
    assign two_h     = {half, 1'b0};
    assign tph       = {1'b0, top} + {1'b0, half};
    assign dph       = {1'b0, d_reg} + {1'b0, h_sv_reg};

    // cell that the result of this beat reads, after the chain has advanced
    always_comb
    begin
        if (last)
        begin
            sel = (tph > {1'b0, cm1}) ? cm1 : tph[IDX_W-1:0];
        end
        else
        begin
            sel = (two_h > {1'b0, cm1}) ? cm1 : two_h[IDX_W-1:0];
        end
    end

    assign drain_sel = (dph > {1'b0, cm1_sv_reg}) ? cm1_sv_reg : dph[IDX_W-1:0];

    assign emit       = last || (cm1 >= half);
    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = !drain_reg && out_free;
    assign in_fire    = in_valid && in_ready;
    assign drain_fire = drain_reg && out_free;
    assign load       = drain_fire || (in_fire && emit);

    // one read port: the tail reads the frozen chain, a live beat reads the
    // neighbour of its target cell and folds in the new pixel
    assign rd_idx = drain_reg ? drain_sel : (sel - 1'b1);

    assign ctrl.advance   = in_fire;
    assign ctrl.row_start = row_start;
    assign ctrl.pixel     = x;

    swmm_chain #(
        .N (MAX_WINDOW)
    ) u_chain (
        .clk     (clk),
        .ctrl    (ctrl),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (row_start || (sel == '0))
        begin
            acc_pix = x;
        end
        else if (take_max_reg)
        begin
            acc_pix = (x > rd_data.mx) ? x : rd_data.mx;
        end
        else
        begin
            acc_pix = (x < rd_data.mn) ? x : rd_data.mn;
        end
    end

    assign drain_pix = take_max_reg ? rd_data.mx : rd_data.mn;

    always_comb
    begin
        if (drain_reg)
        begin
            res.pixel_out    = drain_pix;
            res.row_last_out = (d_reg == '0);
        end
        else
        begin
            res.pixel_out    = acc_pix;
            res.row_last_out = last && (top == '0);
        end
    end

    // advance the row count, saturating; drop it to zero at row end
    always_comb
    begin
        count_next = count_reg;
        if (in_fire)
        begin
            if (last)
            begin
                count_next = '0;
            end
            else if (int'(count_reg) < MAX_WINDOW)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WS_W'(3);
            take_max_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_SIZE: window_size_reg <= cfg_data;
                REG_TAKE_MAX:    take_max_reg    <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // row count, tail control and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drain_reg     <= 1'b0;
            d_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;

            if (in_fire && last && (top != '0))
            begin
                drain_reg <= 1'b1;
                d_reg     <= top - 1'b1;
            end
            else if (drain_fire)
            begin
                if (d_reg == '0)
                begin
                    drain_reg <= 1'b0;
                end
                else
                begin
                    d_reg <= d_reg - 1'b1;
                end
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: tail geometry and the result beat
    always_ff @(posedge clk)
    begin
        if (in_fire && last)
        begin
            h_sv_reg   <= half;
            cm1_sv_reg <= cm1;
        end
        if (load)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a flagged row end in the output register leaves no tail behind it
    `SWMM_ASSERT_NOW(a_last_ends_tail, out_valid_reg && out_data_reg.row_last_out, !drain_reg)
    // every tail step puts a beat into the output register
    `SWMM_ASSERT_NEXT(a_tail_loads, drain_reg && out_free, out_valid_reg)
    // the row count restarts after the last pixel of a row
    `SWMM_ASSERT_NEXT(a_row_restart, in_fire && last, count_reg == '0)

endmodule
`default_nettype wire

/* dv/sliding_window_max_min_filter_1d_test.sv */
// ----------------------------------------------------------------------------
// sliding_window_max_min_filter_1d_test
// Self-checking bench for the 1-D sliding window max/min filter. Rows of
// pixels are streamed in on the input channel. A behavioural predictor
// works out every output pixel and its end-of-row flag for each beat taken,
// and the monitor compares each output beat against the oldest one.
// Phases use fixed and random window sizes between 0 and 63, both operations
// and several patterns of source idling and sink stalling.
// ----------------------------------------------------------------------------
module sliding_window_max_min_filter_1d_test;

    import swmm_pkg::*;

    localparam int MAX_WIN     = 63;
    localparam int HALF_LIMIT  = (MAX_WIN - 1) / 2;
    // Longest tail after a row end is HALF_LIMIT results; allow some margin
    localparam int SETTLE_CYC  = 40;
    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;

    typedef struct {
        pix_in_t beat;
        bit      drain_first;   // hold this beat back until no result is owed
    } pending_beat_t;

    logic      clk;
    logic      rst_n = 1'b0;

    logic      in_valid  = 1'b0;
    logic      in_ready;
    pix_in_t   in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    pix_out_t  out_data;
    logic      cfg_we    = 1'b0;
    cfg_reg_t  cfg_index = REG_WINDOW_SIZE;
    logic [WS_W-1:0] cfg_data = '0;

    // Beats waiting to be offered, results owed by the block
    pending_beat_t   pending_beats[$];
    pix_out_t        expected_pixels[$];

    // Predictor state: configuration copy and the pixels of the current row
    logic [WS_W-1:0]  window_size_m = 6'd3;
    logic             take_max_m    = 1'b1;
    logic [PIX_W-1:0] row_history[MAX_WIN];
    int unsigned      row_count = 0;

    // Traffic shaping, set by the sequencing block at a falling edge
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          want_long_hold = 1'b0;

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;

    sliding_window_max_min_filter_1d #(
        .MAX_WINDOW (MAX_WIN)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Max or min over the newest hi+1 pixels of the row
    function automatic logic [PIX_W-1:0] window_extreme(int unsigned hi);
        logic [PIX_W-1:0] acc;
        acc = row_history[0];
        for (int unsigned k = 1; k <= hi; k++)
        begin
            if (take_max_m ? (row_history[k] > acc) : (row_history[k] < acc))
                acc = row_history[k];
        end
        return acc;
    endfunction

    // Advance the row state by one beat and queue the output pixels it releases
    task automatic predict_beat(input pix_in_t b);
        int unsigned half;
        int unsigned c;
        int unsigned hi;
        int          d;
        pix_out_t    r;
        half = int'(window_size_m) >> 1;
        if (half > HALF_LIMIT)
            half = HALF_LIMIT;
        for (int k = MAX_WIN - 1; k > 0; k--)
            row_history[k] = row_history[k-1];
        row_history[0] = b.pixel_in;
        if (row_count < MAX_WIN)
            row_count++;
        c = row_count;
        if (!b.row_last_in)
        begin
            // Inside a row: emit output j once pixel j+half has arrived
            if (c > half)
            begin
                hi = 2 * half;
                if (hi > c - 1)
                    hi = c - 1;
                r.pixel_out    = window_extreme(hi);
                r.row_last_out = 1'b0;
                expected_pixels = {expected_pixels, r};
            end
        end
        else
        begin
            // Row end: flush every pending output, the window clipped on the right
            d = int'((half < c - 1) ? half : c - 1);
            for (; d >= 0; d--)
            begin
                hi = d + half;
                if (hi > c - 1)
                    hi = c - 1;
                r.pixel_out    = window_extreme(hi);
                r.row_last_out = (d == 0);
                expected_pixels = {expected_pixels, r};
            end
            row_count = 0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer pending beats, predict each one as it is taken
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_beat(in_data);
            // Hold the beat on offer until the block takes it
            if (!(in_valid && !in_ready))
            begin
                if (pending_beats.size() != 0
                    && !(pending_beats[0].drain_first && expected_pixels.size() != 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    pending_beat_t nb;
                    nb = pending_beats.pop_front();
                    in_valid <= 1'b1;
                    in_data  <= nb.beat;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check output beats, shape out_ready
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected output beat, expected none, got %0d last=%0b",
                             $time, out_data.pixel_out, out_data.row_last_out);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    pix_out_t want;
                    bit       bad;
                    want = expected_pixels.pop_front();
                    bad  = 1'b0;
                    if (out_data.pixel_out !== want.pixel_out)
                    begin
                        $display("%0t: pixel_out mismatch, expected %0d, got %0d",
                                 $time, want.pixel_out, out_data.pixel_out);
                        bad = 1'b1;
                    end
                    if (out_data.row_last_out !== want.row_last_out)
                    begin
                        $display("%0t: row_last_out mismatch, expected %0b, got %0b",
                                 $time, want.row_last_out, out_data.row_last_out);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatch_count <= mismatch_count + 1;
                end
            end
            // One long hold-off, counted here, lets the block back up into its input
            if (want_long_hold && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no beat moves on either channel for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------------

    task automatic push_beat(input logic [PIX_W-1:0] p, input logic last,
                             input bit drain = 1'b0);
        pending_beat_t e;
        e.beat.pixel_in    = p;
        e.beat.row_last_in = last;
        e.drain_first      = drain;
        pending_beats = {pending_beats, e};
    endtask

    // Wait until nothing is queued or owed, then let any row-end tail run out
    task automatic settle_idle();
        while (pending_beats.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [WS_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_WINDOW_SIZE)
            window_size_m = val;
        else
            take_max_m = val[0];
    endtask

    // Random rows totalling n beats; leave the last row open if asked
    task automatic queue_rows(input int n, input bit open_end, input int drain_at);
        int pushed;
        int len;
        int style;
        logic [PIX_W-1:0] level;
        logic [PIX_W-1:0] p;
        pushed = 0;
        while (pushed < n)
        begin
            // Mostly short rows of up to 20, now and then one of 21 to 70 that may pass the store depth
            len   = ($urandom_range(8) == 0) ? $urandom_range(21, 70) : $urandom_range(1, 20);
            if (pushed + len > n)
                len = n - pushed;
            style = $urandom_range(3);
            level = PIX_W'($urandom_range(255));
            for (int i = 0; i < len; i++)
            begin
                case (style)
                    0:       p = $urandom_range(1) ? 8'hFF : 8'h00;
                    1:       p = PIX_W'(level + $urandom_range(7) - 3);
                    default: p = PIX_W'($urandom_range(255));
                endcase
                push_beat(p, (i == len - 1) && !(open_end && pushed + len == n),
                          pushed == drain_at);
                pushed++;
            end
        end
    endtask

    task automatic run_phase(input logic [WS_W-1:0] ws, input logic tm,
                             input int unsigned s_pct, input int unsigned r_pct,
                             input int n, input bit open_end, input int drain_at,
                             input bit long_hold);
        settle_idle();
        write_reg(REG_WINDOW_SIZE, ws);
        write_reg(REG_TAKE_MAX, {{(WS_W-1){1'b0}}, tm});
        @(negedge clk);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        if (long_hold)
            want_long_hold = 1'b1;
        queue_rows(n, open_end, drain_at);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings (window 3, maximum): single-pixel rows at both
        // extremes, alternating extremes, and a row shorter than half+1
        push_beat(8'h00, 1'b1);
        push_beat(8'hFF, 1'b1);
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h00, 1'b1);
        push_beat(8'h0A, 1'b1);
        push_beat(8'hFF, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'h00, 1'b1);

        // Same window, minimum
        settle_idle();
        write_reg(REG_TAKE_MAX, {{(WS_W-1){1'b0}}, 1'b0});
        @(negedge clk);
        push_beat(8'hFF, 1'b1);
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h80, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h00, 1'b1);

        // Random phases: pass-through, even and zero sizes, widest window,
        // a register change inside a row, and assorted sizes
        run_phase(6'd1,  1'b0, 0,  0,  38, 1'b0, -1, 1'b1);
        run_phase(6'd2,  1'b1, 63, 0,  38, 1'b0, -1, 1'b0);
        run_phase(6'd0,  1'b0, 0,  63, 38, 1'b0, -1, 1'b0);
        run_phase(6'd63, 1'b1, 24, 24, 45, 1'b0, -1, 1'b0);
        run_phase(6'd63, 1'b0, 0,  0,  40, 1'b0, 20, 1'b0);
        run_phase(6'd5,  1'b1, 63, 0,  38, 1'b1, -1, 1'b0);
        run_phase(6'($urandom_range(1, 63)), 1'($urandom_range(1)), 0, 63, 38,
                  1'b0, -1, 1'b0);
        run_phase(6'($urandom_range(1, 63) | 1), 1'($urandom_range(1)), 24, 24, 38,
                  1'b0, -1, 1'b0);
        run_phase(6'd3,  1'b0, 0,  0,  38, 1'b0, -1, 1'b0);

        // Drain everything and let the tail of the last row run out
        settle_idle();

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
